>>> hdl/ihcs_pkg.sv
// ihcs_pkg: shared types and constants of the interrupt/halt cycle sequencer.
// No dependencies; imported by interrupt_halt_cycle_sequencer_core.
package ihcs_pkg;

    // Input item opcodes
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_RAISE    = 2'd1,
        OP_WR_ENABLE = 2'd2,
        OP_WR_FLAG  = 2'd3
    } opcode_t;

    // Result item action codes
    typedef enum logic [2:0] {
        ACT_REG_ACCESS = 3'd0,
        ACT_IDLE       = 3'd1,
        ACT_HALTED     = 3'd2,
        ACT_EXECUTE    = 3'd3,
        ACT_SERVICE    = 3'd4
    } action_t;

    // Master-enable side effect of an executed instruction
    typedef enum logic [1:0] {
        IME_NONE    = 2'd0,
        IME_DISABLE = 2'd1,
        IME_ENABLE  = 2'd2,
        IME_RETI    = 2'd3
    } ime_action_t;

    localparam int unsigned IRQ_COUNT = 5;
    localparam logic [2:0] IRQ_LIMIT = 3'(IRQ_COUNT);
    localparam logic [6:0] IRQ_BASE = 7'h40;
    localparam logic [3:0] SERVICE_IDLE = 4'd5;

endpackage

>>> hdl/interrupt_halt_cycle_sequencer_core.sv
// interrupt_halt_cycle_sequencer_core: top level of the interrupt/halt sequencer.
// Depends on ihcs_pkg for opcodes, action codes and constants.

// Interrupt and halt sequencer of an 8-bit CPU. Each input transfer is one
// machine cycle: a clock tick, an interrupt request, or a write of the enable
// (IE) or flag (IF) register. Every input transfer yields exactly one output
// transfer, in order, carrying the action taken (register access, idle, halted,
// execute, service), the handler vector when an interrupt is serviced (0x40+8n,
// lowest pending n of five wins), and the IE/IF/IME/halt state after the item.
// Rate: one item per clock while out_stall is low. Result valid rises as the
// item moves from the input register into the result register: the
// item is captured in an input register, then a single short combinational
// pass (priority pick, 4-bit idle add, flag update) updates the sequencer state
// and loads the result register in the same edge.
// The state is read and written only in that pass, so back-to-back items see
// each other's effects exactly in order. The input side keeps accepting while
// a finished result is waiting, as long as the input register is free to move.
module interrupt_halt_cycle_sequencer_core (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [2:0] irq_index,
    input  logic [7:0] write_value,
    input  logic [2:0] instr_cycles,
    input  logic       instr_halts,
    input  logic [1:0] ime_action,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] action,
    output logic [6:0] vector,
    output logic [7:0] enable_bits,
    output logic [7:0] flag_bits,
    output logic       master_enable,
    output logic       halted
);
    import ihcs_pkg::*;

    // ---------------- handshake / pipeline control ----------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_free, s1_fire, in_take;

    // input register (payload, no reset)
    logic [1:0] opcode_reg;
    logic [2:0] irq_index_reg;
    logic [7:0] write_value_reg;
    logic [2:0] instr_cycles_reg;
    logic       instr_halts_reg;
    logic [1:0] ime_action_reg;

    // sequencer state
    logic [7:0] enable_reg, enable_next;
    logic [7:0] flag_reg, flag_next;
    logic       ime_reg, ime_next;
    logic       halt_reg, halt_next;
    logic [3:0] idle_reg, idle_next;

    // result register
    logic [2:0] action_reg;
    logic [6:0] vector_reg;
    logic [6:0] vec_next;
    action_t    act_next;

    // combinational helpers
    logic [4:0] pending;
    logic [2:0] irq_n;
    logic       do_issue;
    logic [2:0] extra_cycles;

    // Result stage can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    // ---------------- single-pass sequencer logic ----------------
    // Only IRQ bits 0..4 can be pending; upper bits are stored only.
    assign pending = enable_reg[4:0] & flag_reg[4:0];

    // lowest pending interrupt number wins
    always_comb
    begin
        irq_n = 3'd0;
        for (int i = IRQ_COUNT - 1; i >= 0; i--)
        begin
            if (pending[i])
            begin
                irq_n = 3'(i);
            end
        end
    end

    // instr_cycles of zero behaves as one
    assign extra_cycles = (instr_cycles_reg == 3'd0) ? 3'd0 : (instr_cycles_reg - 3'd1);

    always_comb
    begin
        enable_next = enable_reg;
        flag_next   = flag_reg;
        ime_next    = ime_reg;
        halt_next   = halt_reg;
        idle_next   = idle_reg;
        act_next    = ACT_REG_ACCESS;
        vec_next    = 7'd0;
        do_issue    = 1'b0;

        case (opcode_t'(opcode_reg))
            OP_RAISE:
            begin
                if (irq_index_reg < IRQ_LIMIT)
                begin
                    flag_next[irq_index_reg] = 1'b1;
                end
            end
            OP_WR_ENABLE:
            begin
                enable_next = write_value_reg;
            end
            OP_WR_FLAG:
            begin
                flag_next = write_value_reg;
            end
            OP_TICK:
            begin
                if (halt_reg && (pending != 5'd0) && (idle_reg == 4'd0))
                begin
                    // wake from halt
                    halt_next = 1'b0;
                    do_issue  = 1'b1;
                end
                else if (idle_reg != 4'd0)
                begin
                    idle_next = idle_reg - 4'd1;
                    act_next  = ACT_IDLE;
                end
                else if (!halt_reg)
                begin
                    do_issue = 1'b1;
                end
                else
                begin
                    act_next = ACT_HALTED;
                end
            end
            default:
            begin
                act_next = ACT_REG_ACCESS;
            end
        endcase

        if (do_issue)
        begin
            if (ime_reg && (pending != 5'd0))
            begin
                // interrupt dispatch
                flag_next[irq_n] = 1'b0;
                ime_next  = 1'b0;
                vec_next  = IRQ_BASE + 7'({irq_n, 3'b000});
                idle_next = idle_reg + SERVICE_IDLE;
                act_next  = ACT_SERVICE;
            end
            else
            begin
                idle_next = idle_reg + {1'b0, extra_cycles};
                if (instr_halts_reg)
                begin
                    halt_next = 1'b1;
                end
                case (ime_action_t'(ime_action_reg))
                    IME_DISABLE: ime_next = 1'b0;
                    IME_ENABLE:  ime_next = 1'b1;
                    IME_RETI:    ime_next = 1'b1;
                    default:     ime_next = ime_reg;
                endcase
                act_next = ACT_EXECUTE;
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            enable_reg    <= 8'd0;
            flag_reg      <= 8'd0;
            ime_reg       <= 1'b0;
            halt_reg      <= 1'b0;
            idle_reg      <= 4'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                enable_reg <= enable_next;
                flag_reg   <= flag_next;
                ime_reg    <= ime_next;
                halt_reg   <= halt_next;
                idle_reg   <= idle_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            opcode_reg       <= opcode;
            irq_index_reg    <= irq_index;
            write_value_reg  <= write_value;
            instr_cycles_reg <= instr_cycles;
            instr_halts_reg  <= instr_halts;
            ime_action_reg   <= ime_action;
        end
        if (s1_fire)
        begin
            action_reg <= act_next;
            vector_reg <= vec_next;
        end
    end

    // State registers hold exactly the after-item state of the result held.
    assign out_valid     = out_valid_reg;
    assign action        = action_reg;
    assign vector        = vector_reg;
    assign enable_bits   = enable_reg;
    assign flag_bits     = flag_reg;
    assign master_enable = ime_reg;
    assign halted        = halt_reg;

`ifndef SYNTH
    // a serviced interrupt always drops the master enable
    a_service_clears_ime: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action == ACT_SERVICE)) |-> !master_enable)
        else $error("service result with master enable set");

    // vector is nonzero only for service results
    a_vector_only_service: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action != ACT_SERVICE)) |-> (vector == 7'd0))
        else $error("vector reported without service");

    // halted result implies halt flag still set
    a_halted_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action == ACT_HALTED)) |-> halted)
        else $error("halted action with halt flag clear");

    // state moves only when an item passes into the result register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> ($stable(idle_reg) && $stable(flag_reg) && $stable(halt_reg)))
        else $error("sequencer state changed without an item");
`endif

endmodule
